// ===== rtl/spso_pkg.sv =====
// Package for the screen pixel shift orbiter: widths, codes and the
// saturation, screen-size and cursor snap helpers. No dependencies.
`timescale 1ns / 1ps

package spso_pkg;

  localparam int COORD_BITS   = 13;
  localparam int OFFSET_W     = 14;
  localparam int CALC_W       = 16;
  localparam int SIZE_W       = 14;
  localparam int MAXO_W       = 8;
  localparam int MARGIN_W     = 10;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 14;
  localparam int OFFSET_LIMIT = 8191;
  localparam int SIZE_LIMIT   = 8192;

  typedef logic signed [OFFSET_W-1:0] offset_t;
  typedef logic signed [CALC_W-1:0]   calc_t;
  typedef logic [SIZE_W-1:0]          size_t;
  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic [MARGIN_W-1:0]        margin_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_OFFSET    = 3'd0,
    CFG_MOUSE_MARGIN  = 3'd1,
    CFG_SCREEN_WIDTH  = 3'd2,
    CFG_SCREEN_HEIGHT = 3'd3,
    CFG_MOUSE_MODE    = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_BOUNCE = 2'd1,
    MODE_PAN    = 2'd2
  } mouse_mode_e;

  typedef enum logic [3:0] {
    PH_LEFT  = 4'b0001,
    PH_UP    = 4'b0010,
    PH_RIGHT = 4'b0100,
    PH_DOWN  = 4'b1000
  } phase_e;

  localparam logic REQ_TICK   = 1'b0;
  localparam logic REQ_CURSOR = 1'b1;

  // Clamp a working value to the legal offset range.
  function automatic offset_t sat_offset(calc_t v);
    offset_t r;
    if (v > calc_t'(OFFSET_LIMIT)) begin
      r = offset_t'(OFFSET_LIMIT);
    end else if (v < -calc_t'(OFFSET_LIMIT)) begin
      r = -offset_t'(OFFSET_LIMIT);
    end else begin
      r = offset_t'(v);
    end
    return r;
  endfunction

  // A zero size counts as one pixel, anything past the limit as the limit.
  function automatic size_t eff_size(size_t s);
    size_t r;
    if (s == '0) begin
      r = size_t'(1);
    end else if (s > size_t'(SIZE_LIMIT)) begin
      r = size_t'(SIZE_LIMIT);
    end else begin
      r = s;
    end
    return r;
  endfunction

  // Move one axis offset just far enough that the cursor window, clamped
  // to the screen, lies inside the visible area.
  function automatic offset_t snap_axis(offset_t off, size_t size, coord_t pos,
                                        margin_t margin);
    calc_t o;
    calc_t p;
    calc_t m;
    calc_t last;
    calc_t lo;
    calc_t hi;
    o    = calc_t'(off);
    p    = calc_t'(pos);
    m    = calc_t'(margin);
    last = calc_t'(size) - calc_t'(1);
    lo   = p - m;
    hi   = p + m;
    if (lo < calc_t'(0)) begin
      lo = '0;
    end
    if (hi > last) begin
      hi = last;
    end
    if (lo < -o) begin
      o = -lo;
    end else if (hi > last - o) begin
      o = last - hi;
    end
    return sat_offset(o);
  endfunction

endpackage

// ===== rtl/spso_ifs.sv =====
// Valid/ready channel interfaces of the screen pixel shift orbiter:
// the request channel and the result channel. Depends on spso_pkg.
`timescale 1ns / 1ps

interface spso_req_if
  import spso_pkg::*;
();
  logic   valid;
  logic   ready;
  logic   req_type;
  coord_t cursor_x;
  coord_t cursor_y;

  modport source (output valid, output req_type, output cursor_x, output cursor_y,
                  input ready);
  modport sink (input valid, input req_type, input cursor_x, input cursor_y,
                output ready);
endinterface

interface spso_rsp_if
  import spso_pkg::*;
();
  logic    valid;
  logic    ready;
  offset_t shift_x;
  offset_t shift_y;
  logic    shift_changed;
  logic    restart_timer;

  modport source (output valid, output shift_x, output shift_y,
                  output shift_changed, output restart_timer, input ready);
  modport sink (input valid, input shift_x, input shift_y,
                input shift_changed, input restart_timer, output ready);
endinterface

// ===== rtl/screen_pixel_shift_orbiter_unit.sv =====
// Top level of the screen pixel shift orbiter: orbit stepping, cursor snap
// and the registered result stage. Depends on spso_pkg and spso_ifs.
`timescale 1ns / 1ps

//  Channel   Direction  Content
//  req_i     in         req_type, cursor_x, cursor_y (tick or cursor event)
//  rsp_o     out        shift_x, shift_y, shift_changed, restart_timer
//  cfg_*_i   in         register write: enable, index, data
//
// Every request beat yields one result beat. The update is computed in the
// cycle a request is taken and lands in the state and result registers at
// that edge, so the result is offered in the next cycle and a request can be
// taken every cycle. The one result register holds off the source only while
// it is full and the sink stalls. Reset clears the offsets, heads the orbit
// left, loads the register defaults and empties the result register.

module screen_pixel_shift_orbiter_unit
  import spso_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  spso_req_if.sink              req_i,
  spso_rsp_if.source            rsp_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Configuration registers.
  logic [MAXO_W-1:0] max_offset_q;
  margin_t           mouse_margin_q;
  size_t             screen_width_q;
  size_t             screen_height_q;
  logic [1:0]        mouse_mode_q;

  // Orbit and applied offset state.
  offset_t target_x_q, target_x_d;
  offset_t target_y_q, target_y_d;
  offset_t applied_x_q, applied_x_d;
  offset_t applied_y_q, applied_y_d;
  phase_e  phase_q, phase_d;

  // Result register.
  logic    rsp_valid_q;
  offset_t rsp_x_q;
  offset_t rsp_y_q;
  logic    rsp_changed_q;
  logic    rsp_restart_q;

  logic    accept;
  logic    step_is_x;
  logic    step_up;
  offset_t step_src;
  offset_t stepped;
  logic    step_done;
  calc_t   maxo;
  size_t   width_eff;
  size_t   height_eff;
  offset_t cand_x;
  offset_t cand_y;
  logic    do_apply;
  logic    bounce;
  logic    changed;

  // The result register empties or drains this cycle, so a request fits.
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.shift_x       = rsp_x_q;
  assign rsp_o.shift_y       = rsp_y_q;
  assign rsp_o.shift_changed = rsp_changed_q;
  assign rsp_o.restart_timer = rsp_restart_q;

  // Left and right phases walk the horizontal axis; right and down count up.
  assign step_is_x  = (phase_q == PH_LEFT) || (phase_q == PH_RIGHT);
  assign step_up    = (phase_q == PH_RIGHT) || (phase_q == PH_DOWN);
  assign step_src   = step_is_x ? target_x_q : target_y_q;
  assign stepped    = sat_offset(calc_t'(step_src) + (step_up ? calc_t'(1) : -calc_t'(1)));
  assign maxo       = calc_t'(max_offset_q);
  assign step_done  = step_up ? (calc_t'(stepped) >= maxo) : (calc_t'(stepped) <= -maxo);
  assign width_eff  = eff_size(screen_width_q);
  assign height_eff = eff_size(screen_height_q);

  always_comb begin
    target_x_d = target_x_q;
    target_y_d = target_y_q;
    phase_d    = phase_q;
    cand_x     = applied_x_q;
    cand_y     = applied_y_q;
    do_apply   = 1'b0;
    bounce     = 1'b0;
    if (req_i.req_type == REQ_TICK) begin
      if (step_is_x) begin
        target_x_d = stepped;
      end else begin
        target_y_d = stepped;
      end
      if (step_done) begin
        phase_d = phase_e'({phase_q[2:0], phase_q[3]});
      end
      cand_x   = step_is_x ? stepped : target_x_q;
      cand_y   = step_is_x ? target_y_q : stepped;
      do_apply = 1'b1;
    end else begin
      case (mouse_mode_q)
        MODE_BOUNCE: begin
          // Only the applied offset moves; the orbit target stays put.
          cand_x   = snap_axis(target_x_q, width_eff, req_i.cursor_x, mouse_margin_q);
          cand_y   = snap_axis(target_y_q, height_eff, req_i.cursor_y, mouse_margin_q);
          do_apply = 1'b1;
          bounce   = 1'b1;
        end
        MODE_PAN: begin
          target_x_d = snap_axis(target_x_q, width_eff, req_i.cursor_x, mouse_margin_q);
          target_y_d = snap_axis(target_y_q, height_eff, req_i.cursor_y, mouse_margin_q);
          cand_x     = target_x_d;
          cand_y     = target_y_d;
          do_apply   = 1'b1;
        end
        default: begin
          do_apply = 1'b0;
        end
      endcase
    end
    changed     = do_apply && ((cand_x != applied_x_q) || (cand_y != applied_y_q));
    applied_x_d = changed ? cand_x : applied_x_q;
    applied_y_d = changed ? cand_y : applied_y_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_offset_q    <= MAXO_W'(8);
      mouse_margin_q  <= '0;
      screen_width_q  <= SIZE_W'(1920);
      screen_height_q <= SIZE_W'(1080);
      mouse_mode_q    <= MODE_NONE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_OFFSET:    max_offset_q    <= cfg_data_i[MAXO_W-1:0];
        CFG_MOUSE_MARGIN:  mouse_margin_q  <= cfg_data_i[MARGIN_W-1:0];
        CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_data_i[SIZE_W-1:0];
        CFG_SCREEN_HEIGHT: screen_height_q <= cfg_data_i[SIZE_W-1:0];
        CFG_MOUSE_MODE:    mouse_mode_q    <= cfg_data_i[1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_x_q  <= '0;
      target_y_q  <= '0;
      applied_x_q <= '0;
      applied_y_q <= '0;
      phase_q     <= PH_LEFT;
    end else if (accept) begin
      target_x_q  <= target_x_d;
      target_y_q  <= target_y_d;
      applied_x_q <= applied_x_d;
      applied_y_q <= applied_y_d;
      phase_q     <= phase_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (accept) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_x_q       <= applied_x_d;
      rsp_y_q       <= applied_y_d;
      rsp_changed_q <= changed;
      rsp_restart_q <= changed && bounce;
    end
  end

endmodule
